/* rtl/cdp_pkg.sv */
// Shared types, widths and the rounding shift function for the complex dot product.
package cdp_pkg;

  localparam int DATA_W      = 32;
  localparam int SHIFT_W     = 5;
  localparam int IN_TDATA_W  = 4 * DATA_W;
  localparam int OUT_TDATA_W = 2 * DATA_W;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [SHIFT_W-1:0]       shamt_t;

  // One accepted input word, unpacked
  typedef struct packed {
    word_t a_re;
    word_t a_im;
    word_t b_re;
    word_t b_im;
    logic  last;
  } pair_t;

  // Low halves of the four partial products
  typedef struct packed {
    word_t rr;
    word_t ii;
    word_t ri;
    word_t ir;
    logic  last;
  } prod_t;

  // Rounded and shifted real and imaginary terms
  typedef struct packed {
    word_t re;
    word_t im;
    logic  last;
  } term_t;

  // Add half an LSB (none for a zero shift), wrap, then shift right arithmetically
  function automatic word_t round_shift(word_t v, shamt_t s);
    word_t rc;
    word_t t;
    rc = '0;
    if (s != '0) begin
      rc = word_t'(1) << (s - shamt_t'(1));
    end
    t = v + rc;
    return t >>> s;
  endfunction

endpackage

/* rtl/cdp_mul.sv */
// Input register and partial product register of the complex dot product.
module cdp_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdp_pkg::pair_t in_pair,
  output logic           prod_valid,
  input  logic           prod_ready,
  output cdp_pkg::prod_t prod
);
  import cdp_pkg::*;

  logic  pair_v_r, pair_v_nxt;
  pair_t pair_r;
  logic  prod_v_r, prod_v_nxt;
  prod_t prod_r, prod_nxt;
  logic  prod_adv;
  logic  pair_adv;

  // Each stage advances when empty or when the next one takes its word
  assign prod_adv = !prod_v_r || prod_ready;
  assign pair_adv = !pair_v_r || prod_adv;
  assign in_ready = pair_adv;

  // Form the four products, kept to their low 32 bits
  always_comb begin
    prod_nxt.rr   = pair_r.a_re * pair_r.b_re;
    prod_nxt.ii   = pair_r.a_im * pair_r.b_im;
    prod_nxt.ri   = pair_r.a_re * pair_r.b_im;
    prod_nxt.ir   = pair_r.a_im * pair_r.b_re;
    prod_nxt.last = pair_r.last;
  end

  always_comb begin
    pair_v_nxt = pair_v_r;
    prod_v_nxt = prod_v_r;
    if (pair_adv) begin
      pair_v_nxt = in_valid;
    end
    if (prod_adv) begin
      prod_v_nxt = pair_v_r;
    end
  end

  // Hold control under reset; payload loads on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      pair_v_r <= pair_v_nxt;
      prod_v_r <= prod_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_adv && in_valid) begin
      pair_r <= in_pair;
    end
    if (prod_adv && pair_v_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = prod_v_r;
  assign prod       = prod_r;

endmodule

/* rtl/cdp_round.sv */
// Term combine and rounding shift register stage.
module cdp_round (
  input  logic            clk,
  input  logic            rst_n,
  input  cdp_pkg::shamt_t shift,
  input  logic            prod_valid,
  output logic            prod_ready,
  input  cdp_pkg::prod_t  prod,
  output logic            term_valid,
  input  logic            term_ready,
  output cdp_pkg::term_t  term
);
  import cdp_pkg::*;

  logic  term_v_r, term_v_nxt;
  term_t term_r, term_nxt;
  logic  term_adv;
  word_t re_raw;
  word_t im_raw;

  assign term_adv   = !term_v_r || term_ready;
  assign prod_ready = term_adv;

  // Combine partial products with wraparound, then round and shift each term
  always_comb begin
    re_raw        = prod.rr - prod.ii;
    im_raw        = prod.ri + prod.ir;
    term_nxt.re   = round_shift(re_raw, shift);
    term_nxt.im   = round_shift(im_raw, shift);
    term_nxt.last = prod.last;
  end

  always_comb begin
    term_v_nxt = term_v_r;
    if (term_adv) begin
      term_v_nxt = prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_v_r <= 1'b0;
    end else begin
      term_v_r <= term_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (term_adv && prod_valid) begin
      term_r <= term_nxt;
    end
  end

  assign term_valid = term_v_r;
  assign term       = term_r;

endmodule

/* rtl/cdp_acc.sv */
// Wrapping accumulators and the result register.
module cdp_acc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  term_valid,
  output logic                  term_ready,
  input  cdp_pkg::term_t        term,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdp_pkg::word_t        c_re,
  output cdp_pkg::word_t        c_im
);
  import cdp_pkg::*;

  word_t acc_re_r, acc_re_nxt;
  word_t acc_im_r, acc_im_nxt;
  logic  out_v_r, out_v_nxt;
  word_t c_re_r;
  word_t c_im_r;
  word_t sum_re;
  word_t sum_im;
  logic  consume;
  logic  emit;

  // A last word needs the result slot free; others always go in
  assign consume    = term_valid && (!term.last || !out_v_r || out_ready);
  assign emit       = consume && term.last;
  assign term_ready = !term.last || !out_v_r || out_ready;

  assign sum_re = acc_re_r + term.re;
  assign sum_im = acc_im_r + term.im;

  // Advance the sums; clear them when a dot product is finished
  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    out_v_nxt  = out_v_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (consume) begin
      if (term.last) begin
        acc_re_nxt = '0;
        acc_im_nxt = '0;
        out_v_nxt  = 1'b1;
      end else begin
        acc_re_nxt = sum_re;
        acc_im_nxt = sum_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (emit) begin
      c_re_r <= sum_re;
      c_im_r <= sum_im;
    end
  end

  assign out_valid = out_v_r;
  assign c_re      = c_re_r;
  assign c_im      = c_im_r;

`ifndef SYNTHESIS
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (acc_re_r == '0) && (acc_im_r == '0))
    else $error("accumulators not cleared after a result");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(emit))
    else $error("result appeared without a last word");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !consume |=> $stable(acc_re_r) && $stable(acc_im_r))
    else $error("accumulators moved without a word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(c_re_r) && $stable(c_im_r))
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/complex_dot_product_round_shift.sv */
// Top level of the complex dot product with per-term rounding shift.
//
// Input channel in_*: one word per pair of complex elements (A row element and
// transposed B element); in_tlast marks the final pair of a dot product.
// Result channel out_*: one word per finished dot product, carrying the
// wrapped 32-bit real and imaginary sums. Words not marked last give no result.
// Config channel cfg_*: writes the 5-bit rounding shift; always ready. Write it
// only while no words are in flight.
// Throughput: one input word per cycle unless a result stall backs up to
// in_tready. A pair passes an input register, a product register (four 32x32
// low-half multipliers), a rounding register and the accumulator, which loads
// the result register. The accumulator add is the only recurrence.
// Reset (rst_n low, synchronous) empties all stages, clears the sums and sets
// the shift to zero.
// When the receiver stalls the result stays in the output register; words keep
// flowing and accumulating until the next last word reaches the accumulator,
// then the stall backs up through the stages to in_tready.
module complex_dot_product_round_shift (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // a_re [31:0], a_im [63:32], b_re [95:64], b_im [127:96]
  input  logic [cdp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // c_re [31:0], c_im [63:32]
  output logic [cdp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdp_pkg::SHIFT_W-1:0]     cfg_data
);
  import cdp_pkg::*;

  shamt_t shift_r;
  pair_t  in_pair;
  prod_t  prod;
  logic   prod_valid;
  logic   prod_ready;
  term_t  term;
  logic   term_valid;
  logic   term_ready;
  word_t  c_re;
  word_t  c_im;

  // Shift register write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_valid) begin
      shift_r <= cfg_data;
    end
  end

  // Unpack the input word
  always_comb begin
    in_pair.a_re = in_tdata[DATA_W-1:0];
    in_pair.a_im = in_tdata[2*DATA_W-1:DATA_W];
    in_pair.b_re = in_tdata[3*DATA_W-1:2*DATA_W];
    in_pair.b_im = in_tdata[4*DATA_W-1:3*DATA_W];
    in_pair.last = in_tlast;
  end

  cdp_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pair    (in_pair),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  cdp_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift      (shift_r),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term)
  );

  cdp_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .c_re       (c_re),
    .c_im       (c_im)
  );

  // Pack the result word
  assign out_tdata = {c_im, c_re};

endmodule
